// File: rtl/bafr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_pkg
// Shared types, codes and reset constants of the region allocator.
// ----------------------------------------------------------------------------
package bafr_pkg;

  localparam int unsigned MIB           = 1048576;
  localparam int          NUM_SLOTS_DEF = 16;

  localparam int WORD_W    = 32;
  localparam int HDR_W     = 16;
  localparam int STAT_W    = 3;
  localparam int FCNT_W    = 5;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [WORD_W-1:0] SEG_RST  = 32'd268435456;
  localparam logic [HDR_W-1:0]  HDR_RST  = 16'd4096;
  localparam logic [WORD_W-1:0] THR_RST  = 32'(MIB);
  localparam logic [WORD_W-1:0] FREE_RST = SEG_RST - {16'd0, HDR_RST};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT   = 2'd0,
    REG_HEADER    = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_t;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // reply status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_NEW         = 3'd0,
    STAT_REUSE       = 3'd1,
    STAT_NOMEM       = 3'd2,
    STAT_FREE_TRK    = 3'd3,
    STAT_FREE_UNTRK  = 3'd4
  } stat_t;

  // shared arithmetic unit operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_ADD_SAT,
    OP_SUB_SAT,
    OP_GE,
    OP_EQ
  } alu_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              flag;
  } alu_res_t;

  // fragment table commands
  typedef struct packed {
    logic clr;
    logic wr;
    logic rel_set;
    logic rel_clr;
  } slot_op_t;

endpackage
`default_nettype wire

// File: rtl/bafr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_req_if
// Request channel: alloc or free word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bafr_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] req_size;
  logic [31:0] req_offset;

  modport source (output valid, req_type, req_size, req_offset, input ready);
  modport sink   (input valid, req_type, req_size, req_offset, output ready);
endinterface
`default_nettype wire

// File: rtl/bafr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_rsp_if
// Reply channel: status, block offset and counters, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bafr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        bad_offset;
  logic [31:0] block_offset;
  logic [31:0] used_total;
  logic [31:0] free_total;
  logic [4:0]  frags_tracked;
  logic [4:0]  frags_busy;
  logic [4:0]  frags_busy_peak;
  logic [31:0] large_total;

  modport source (output valid, status, bad_offset, block_offset, used_total,
                  free_total, frags_tracked, frags_busy, frags_busy_peak,
                  large_total, input ready);
  modport sink   (input valid, status, bad_offset, block_offset, used_total,
                  free_total, frags_tracked, frags_busy, frags_busy_peak,
                  large_total, output ready);
endinterface
`default_nettype wire

// File: rtl/bafr_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_alu
// Shared 32-bit add/subtract unit with saturation, compare and equality.
// ----------------------------------------------------------------------------
module bafr_alu (
  input  bafr_pkg::alu_op_t  op,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output bafr_pkg::alu_res_t res
);

  logic        sub;
  logic [31:0] b_eff;
  logic [32:0] sum;

  // one adder; subtract by inverting b and carrying in
  assign sub   = (op == bafr_pkg::OP_SUB_SAT) || (op == bafr_pkg::OP_GE);
  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {32'd0, sub};

  always_comb begin
    res.value = sum[31:0];
    res.flag  = sum[32];
    case (op)
      bafr_pkg::OP_ADD: begin
        res.value = sum[31:0];
        res.flag  = sum[32];
      end
      bafr_pkg::OP_ADD_SAT: begin
        res.value = sum[32] ? '1 : sum[31:0];
        res.flag  = sum[32];
      end
      bafr_pkg::OP_SUB_SAT: begin
        // carry out set means no borrow
        res.value = sum[32] ? sum[31:0] : '0;
        res.flag  = sum[32];
      end
      bafr_pkg::OP_GE: begin
        res.value = sum[31:0];
        res.flag  = sum[32];
      end
      bafr_pkg::OP_EQ: begin
        res.value = sum[31:0];
        res.flag  = (a == b);
      end
      default: begin
        res.value = sum[31:0];
        res.flag  = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/bafr_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bafr_slot_table
// Fragment table: offset/size memory with registered read, plus valid and
// released flags kept in flops.
// ----------------------------------------------------------------------------
module bafr_slot_table #(
  parameter int NUM_SLOTS = bafr_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bafr_pkg::slot_op_t   op,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [31:0]          rd_offset,
  output logic [31:0]          rd_size,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [31:0]          wr_offset,
  input  logic [31:0]          wr_size,
  output logic [NUM_SLOTS-1:0] valid,
  output logic [NUM_SLOTS-1:0] released
);

  logic [31:0] mem_offset [NUM_SLOTS];
  logic [31:0] mem_size   [NUM_SLOTS];

  // payload memory, one write and one read port
  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem_offset[wr_addr] <= wr_offset;
      mem_size[wr_addr]   <= wr_size;
    end
    rd_offset <= mem_offset[rd_addr];
    rd_size   <= mem_size[rd_addr];
  end

  // per-slot flags
  always_ff @(posedge clk) begin
    if (rst || op.clr) begin
      valid    <= '0;
      released <= '0;
    end else begin
      if (op.wr) begin
        valid[wr_addr]    <= 1'b1;
        released[wr_addr] <= 1'b0;
      end
      if (op.rel_set) released[wr_addr] <= 1'b1;
      if (op.rel_clr) released[wr_addr] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bump_allocator_large_frag_recycle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bump_allocator_large_frag_recycle_core
// Region allocator with bump pointer and recycling of large fragments.
// ----------------------------------------------------------------------------
// Usage:
//   req carries alloc/free words, rsp returns one reply word per request.
//   cfg_we/cfg_index/cfg_data write segment_bytes, header_bytes and
//   large_threshold; a geometry write restarts the allocator (req.ready low
//   in the write cycle and while the restart state runs).
// Throughput:
//   One request at a time. The next request is taken at the earliest at the
//   first edge at which the previous reply word can be taken. The table scan
//   reads one slot a cycle through the registered memory port, and every add,
//   subtract and compare on sizes, offsets and byte totals goes through the
//   one shared ALU.
// Reset:
//   rst (synchronous) loads the default geometry and free count, zeroes the
//   other counters and the table's flags; the reply register comes up empty.
// Stall:
//   A finished reply sits in the output register; the next request is
//   accepted meanwhile but its own reply waits until rsp.ready takes the word.
// ----------------------------------------------------------------------------
module bump_allocator_large_frag_recycle_core #(
  parameter int NUM_SLOTS = bafr_pkg::NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bafr_req_if.sink              req,
  bafr_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [bafr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CW     = (SCNT_W > bafr_pkg::FCNT_W) ? SCNT_W : bafr_pkg::FCNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RESTART, S_CLASS, S_SCAN, S_FLO, S_FHI,
    S_BUMP, S_FIT, S_USED, S_FREE, S_LARGE, S_REPLY
  } state_t;

  state_t state;

  // configuration
  logic [31:0] seg;
  logic [15:0] hdr;
  logic [31:0] thr;

  // allocator state
  logic [31:0] next_free;
  logic [31:0] used_count;
  logic [31:0] free_count;
  logic [31:0] large_bytes;
  logic [CW-1:0] tracked_count;
  logic [CW-1:0] busy_count;
  logic [CW-1:0] busy_peak;

  // current request
  logic        is_free;
  logic [31:0] size_q;
  logic [31:0] off_q;
  logic        large_q;
  logic        lo_ok;
  bafr_pkg::stat_t status_q;
  logic        bad_q;
  logic [31:0] blk_q;
  logic [31:0] sum_q;
  logic        carry_q;

  // scan control
  logic [SCNT_W-1:0] iss_cnt;
  logic              chk_en;
  logic [IDX_W-1:0]  chk_idx;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;

  // reply register
  logic        out_valid;
  bafr_pkg::stat_t out_status;
  logic        out_bad;
  logic [31:0] out_blk;
  logic [31:0] out_used;
  logic [31:0] out_free;
  logic [4:0]  out_tracked;
  logic [4:0]  out_busy;
  logic [4:0]  out_peak;
  logic [31:0] out_large;

  // table and ALU wiring
  bafr_pkg::slot_op_t  slot_op;
  logic [IDX_W-1:0]    wr_addr;
  logic [31:0]         rd_offset;
  logic [31:0]         rd_size;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_released;

  bafr_pkg::alu_op_t   alu_op;
  logic [31:0]         alu_a;
  logic [31:0]         alu_b;
  bafr_pkg::alu_res_t  alu_r;

  logic          vld_c;
  logic          rel_c;
  logic          hit_c;
  logic          last_c;
  logic          issue_c;
  logic          restart_c;
  logic          load_c;
  logic [CW-1:0] busy_inc;
  logic [CW-1:0] peak_inc;

  bafr_slot_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .op        (slot_op),
    .rd_addr   (iss_cnt[IDX_W-1:0]),
    .rd_offset (rd_offset),
    .rd_size   (rd_size),
    .wr_addr   (wr_addr),
    .wr_offset (blk_q),
    .wr_size   (size_q),
    .valid     (slot_valid),
    .released  (slot_released)
  );

  bafr_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_r)
  );

  // ALU operand select per sequencer step
  always_comb begin
    alu_op = bafr_pkg::OP_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_RESTART: begin
        alu_op = bafr_pkg::OP_SUB_SAT; alu_a = seg;        alu_b = {16'd0, hdr};
      end
      S_CLASS: begin
        alu_op = bafr_pkg::OP_GE;      alu_a = size_q;     alu_b = thr;
      end
      S_SCAN: begin
        if (is_free) begin
          alu_op = bafr_pkg::OP_EQ;    alu_a = rd_offset;  alu_b = off_q;
        end else begin
          alu_op = bafr_pkg::OP_GE;    alu_a = rd_size;    alu_b = size_q;
        end
      end
      S_FLO: begin
        alu_op = bafr_pkg::OP_GE;      alu_a = off_q;      alu_b = {16'd0, hdr};
      end
      S_FHI: begin
        alu_op = bafr_pkg::OP_GE;      alu_a = off_q;      alu_b = seg;
      end
      S_BUMP: begin
        alu_op = bafr_pkg::OP_ADD;     alu_a = next_free;  alu_b = size_q;
      end
      S_FIT: begin
        alu_op = bafr_pkg::OP_GE;      alu_a = sum_q;      alu_b = seg;
      end
      S_USED: begin
        alu_op = bafr_pkg::OP_ADD_SAT; alu_a = used_count; alu_b = size_q;
      end
      S_FREE: begin
        alu_op = bafr_pkg::OP_SUB_SAT; alu_a = free_count; alu_b = size_q;
      end
      S_LARGE: begin
        alu_op = bafr_pkg::OP_ADD_SAT; alu_a = large_bytes; alu_b = size_q;
      end
      default: begin
        alu_op = bafr_pkg::OP_ADD;
      end
    endcase
  end

  // scan match and counter helpers
  assign vld_c    = slot_valid[chk_idx];
  assign rel_c    = slot_released[chk_idx];
  assign hit_c    = chk_en && vld_c && alu_r.flag && (is_free || rel_c);
  assign last_c   = chk_en && (chk_idx == IDX_W'(NUM_SLOTS - 1));
  assign issue_c  = (iss_cnt < SCNT_W'(NUM_SLOTS));
  assign busy_inc = busy_count + CW'(1);
  assign peak_inc = (busy_inc > busy_peak) ? busy_inc : busy_peak;

  // geometry write and reply load
  assign restart_c = cfg_we && ((cfg_index == bafr_pkg::REG_SEGMENT) ||
                                (cfg_index == bafr_pkg::REG_HEADER));
  assign load_c    = (state == S_REPLY) && !restart_c && (!out_valid || rsp.ready);

  // fragment table commands
  always_comb begin
    slot_op = '0;
    wr_addr = chk_idx;
    case (state)
      S_RESTART: slot_op.clr = 1'b1;
      S_SCAN: begin
        if (hit_c) begin
          if (is_free) slot_op.rel_set = !rel_c;
          else         slot_op.rel_clr = 1'b1;
        end
      end
      S_LARGE: begin
        slot_op.wr = 1'b1;
        wr_addr    = empty_idx;
      end
      default: slot_op = '0;
    endcase
  end

  // sequencer, state and reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seg           <= bafr_pkg::SEG_RST;
      hdr           <= bafr_pkg::HDR_RST;
      thr           <= bafr_pkg::THR_RST;
      next_free     <= {16'd0, bafr_pkg::HDR_RST};
      used_count    <= '0;
      free_count    <= bafr_pkg::FREE_RST;
      large_bytes   <= '0;
      tracked_count <= '0;
      busy_count    <= '0;
      busy_peak     <= '0;
      out_valid     <= 1'b0;
      iss_cnt       <= '0;
      chk_en        <= 1'b0;
      empty_found   <= 1'b0;
    end else begin
      if (load_c)         out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;

      if (restart_c) begin
        state <= S_RESTART;
      end else begin
        case (state)
          S_IDLE: begin
            if (req.valid) begin
              is_free     <= req.req_type;
              size_q      <= req.req_size;
              off_q       <= req.req_offset;
              bad_q       <= 1'b0;
              blk_q       <= '0;
              large_q     <= 1'b0;
              iss_cnt     <= '0;
              chk_en      <= 1'b0;
              empty_found <= 1'b0;
              state       <= (req.req_type == bafr_pkg::REQ_FREE) ? S_SCAN : S_CLASS;
            end
          end
          S_RESTART: begin
            next_free     <= {16'd0, hdr};
            used_count    <= '0;
            free_count    <= alu_r.value;
            large_bytes   <= '0;
            tracked_count <= '0;
            busy_count    <= '0;
            busy_peak     <= '0;
            state         <= S_IDLE;
          end
          S_CLASS: begin
            large_q <= alu_r.flag;
            state   <= alu_r.flag ? S_SCAN : S_BUMP;
          end
          S_SCAN: begin
            // issue one read a cycle, check the slot read last cycle
            chk_en  <= issue_c;
            chk_idx <= iss_cnt[IDX_W-1:0];
            if (issue_c) iss_cnt <= iss_cnt + SCNT_W'(1);
            if (chk_en && !vld_c && !empty_found && !is_free) begin
              empty_found <= 1'b1;
              empty_idx   <= chk_idx;
            end
            if (hit_c) begin
              if (is_free) begin
                status_q <= bafr_pkg::STAT_FREE_TRK;
                if (!rel_c && (busy_count != '0)) busy_count <= busy_count - CW'(1);
                state <= S_FLO;
              end else begin
                status_q   <= bafr_pkg::STAT_REUSE;
                blk_q      <= rd_offset;
                busy_count <= busy_inc;
                busy_peak  <= peak_inc;
                state      <= S_REPLY;
              end
            end else if (last_c) begin
              if (is_free) begin
                status_q <= bafr_pkg::STAT_FREE_UNTRK;
                state    <= S_FLO;
              end else begin
                state <= S_BUMP;
              end
            end
          end
          S_FLO: begin
            lo_ok <= alu_r.flag;
            state <= S_FHI;
          end
          S_FHI: begin
            bad_q <= !lo_ok || alu_r.flag;
            state <= S_REPLY;
          end
          S_BUMP: begin
            // new pointer, carry kept for the fit check
            sum_q   <= alu_r.value;
            carry_q <= alu_r.flag;
            state   <= S_FIT;
          end
          S_FIT: begin
            // fail when the new pointer reaches the end, exact fit included
            if (carry_q || alu_r.flag) begin
              status_q <= bafr_pkg::STAT_NOMEM;
              state    <= S_REPLY;
            end else begin
              status_q  <= bafr_pkg::STAT_NEW;
              blk_q     <= next_free;
              next_free <= sum_q;
              state     <= S_USED;
            end
          end
          S_USED: begin
            used_count <= alu_r.value;
            state      <= S_FREE;
          end
          S_FREE: begin
            free_count <= alu_r.value;
            state      <= (large_q && empty_found) ? S_LARGE : S_REPLY;
          end
          S_LARGE: begin
            large_bytes   <= alu_r.value;
            tracked_count <= tracked_count + CW'(1);
            busy_count    <= busy_inc;
            busy_peak     <= peak_inc;
            state         <= S_REPLY;
          end
          S_REPLY: begin
            if (load_c) begin
              out_status  <= status_q;
              out_bad     <= bad_q;
              out_blk     <= blk_q;
              out_used    <= used_count;
              out_free    <= free_count;
              out_tracked <= tracked_count[4:0];
              out_busy    <= busy_count[4:0];
              out_peak    <= busy_peak[4:0];
              out_large   <= large_bytes;
              state       <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end

      // register writes; geometry writes restart the allocator above
      if (cfg_we) begin
        case (cfg_index)
          bafr_pkg::REG_SEGMENT:   seg <= cfg_data;
          bafr_pkg::REG_HEADER:    hdr <= cfg_data[15:0];
          bafr_pkg::REG_THRESHOLD: thr <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign req.ready           = (state == S_IDLE) && !restart_c;
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.bad_offset      = out_bad;
  assign rsp.block_offset    = out_blk;
  assign rsp.used_total      = out_used;
  assign rsp.free_total      = out_free;
  assign rsp.frags_tracked   = out_tracked;
  assign rsp.frags_busy      = out_busy;
  assign rsp.frags_busy_peak = out_peak;
  assign rsp.large_total     = out_large;

  // tracked count follows the table's valid flags
  a_tracked_match: assert property (@(posedge clk) disable iff (rst)
    int'(tracked_count) == $countones(slot_valid))
    else $error("tracked count differs from valid slots");

  // in-use count follows valid slots that are not released
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    int'(busy_count) == $countones(slot_valid & ~slot_released))
    else $error("busy count differs from in-use slots");

  // peak never below the current in-use count
  a_peak_ge_busy: assert property (@(posedge clk) disable iff (rst)
    busy_peak >= busy_count)
    else $error("busy peak below busy count");

  // an accepted word starts work right away
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("accepted word did not start");

  // failed allocations and frees hand out no block
  a_no_block_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == bafr_pkg::STAT_NOMEM ||
                  rsp.status == bafr_pkg::STAT_FREE_TRK ||
                  rsp.status == bafr_pkg::STAT_FREE_UNTRK) |-> rsp.block_offset == '0)
    else $error("block offset set on failed alloc or free");

endmodule
`default_nettype wire

// File: tb/tb_bump_allocator_large_frag_recycle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bump_allocator_large_frag_recycle_core
// Self-checking bench for the region allocator. A table of directed requests
// runs first. Random phases follow, each under its own geometry. Every request
// word that is accepted runs through a shadow allocator. Each reply word is
// compared with the oldest expected reply (the table's for fixed rows, else
// the shadow's). Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_bump_allocator_large_frag_recycle_core;
  import bafr_pkg::*;

  localparam int NSLOT          = NUM_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = NSLOT + 12;
  localparam int N_PHASES       = 7;
  localparam int LIVE_MAX       = 64;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    stat_t       status;
    logic        bad;
    logic [31:0] blk;
    logic [31:0] used;
    logic [31:0] free;
    logic [4:0]  trk;
    logic [4:0]  busy;
    logic [4:0]  peak;
    logic [31:0] lg_bytes;
  } reply_t;

  typedef struct {
    logic        kind;
    logic [31:0] size;
    logic [31:0] off;
    bit          fixed;
    reply_t      want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  bafr_req_if req_ch ();
  bafr_rsp_if rsp_ch ();

  bump_allocator_large_frag_recycle_core #(
    .NUM_SLOTS(NSLOT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow registers
  logic [31:0] m_seg;
  logic [15:0] m_hdr;
  logic [31:0] m_thr;

  // shadow allocator state
  logic [31:0] m_next;
  logic [31:0] m_used;
  logic [31:0] m_free;
  logic [31:0] m_large;
  logic [31:0] m_frag_off  [NSLOT];
  logic [31:0] m_frag_size [NSLOT];
  logic        m_frag_valid[NSLOT];
  logic        m_frag_rel  [NSLOT];
  logic [4:0]  m_trk;
  logic [4:0]  m_busy;
  logic [4:0]  m_peak;

  reply_t      pending_replies[$];
  logic [31:0] live_blocks[$];
  stim_row_t   dir_tab[$];

  // word on the request channel, as seen by the monitor
  bit          pend_fixed;
  reply_t      pend_want;

  int          send_idle_pct;
  int          stall_pct;
  int          fail_cnt;
  int          quiet_cycles;

  // --------------------------------------------------------------------------
  // shadow allocator
  // --------------------------------------------------------------------------
  function automatic void restart_region();
    int i;
    m_next = {16'd0, m_hdr};
    m_used = '0;
    m_free = (m_seg >= {16'd0, m_hdr}) ? m_seg - {16'd0, m_hdr} : '0;
    for (i = 0; i < NSLOT; i++) begin
      m_frag_valid[i] = 1'b0;
      m_frag_rel[i]   = 1'b0;
    end
    m_trk   = '0;
    m_busy  = '0;
    m_peak  = '0;
    m_large = '0;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void busy_up();
    m_busy = m_busy + 5'd1;
    if (m_busy > m_peak) m_peak = m_busy;
  endfunction

  function automatic reply_t predict_reply(input logic kind, input logic [31:0] size,
                                           input logic [31:0] off);
    reply_t r;
    logic   big;
    logic   hit;
    int     i;
    r        = '0;
    r.status = STAT_NOMEM;
    hit      = 1'b0;
    if (kind == REQ_ALLOC) begin
      big = (size >= m_thr);
      // large request: first released fragment that is big enough
      if (big) begin
        for (i = 0; i < NSLOT; i++) begin
          if (!hit && m_frag_valid[i] && m_frag_rel[i] && m_frag_size[i] >= size) begin
            m_frag_rel[i] = 1'b0;
            busy_up();
            r.blk    = m_frag_off[i];
            r.status = STAT_REUSE;
            hit      = 1'b1;
          end
        end
      end
      // bump pointer; exact fit counts as no room
      if (!hit && ({1'b0, m_next} + {1'b0, size} < {1'b0, m_seg})) begin
        r.status = STAT_NEW;
        r.blk    = m_next;
        m_next   = m_next + size;
        m_used   = sat_add32(m_used, size);
        m_free   = (m_free >= size) ? m_free - size : '0;
        if (big) begin
          for (i = 0; i < NSLOT; i++) begin
            if (!hit && !m_frag_valid[i]) begin
              m_frag_valid[i] = 1'b1;
              m_frag_rel[i]   = 1'b0;
              m_frag_off[i]   = r.blk;
              m_frag_size[i]  = size;
              m_trk           = m_trk + 5'd1;
              busy_up();
              m_large = sat_add32(m_large, size);
              hit     = 1'b1;
            end
          end
        end
      end
    end else begin
      r.bad    = !(off >= {16'd0, m_hdr} && off < m_seg);
      r.status = STAT_FREE_UNTRK;
      for (i = 0; i < NSLOT; i++) begin
        if (!hit && m_frag_valid[i] && m_frag_off[i] == off) begin
          if (!m_frag_rel[i]) begin
            m_frag_rel[i] = 1'b1;
            if (m_busy != 5'd0) m_busy = m_busy - 5'd1;
          end
          r.status = STAT_FREE_TRK;
          hit      = 1'b1;
        end
      end
    end
    r.used     = m_used;
    r.free     = m_free;
    r.trk      = m_trk;
    r.busy     = m_busy;
    r.peak     = m_peak;
    r.lg_bytes = m_large;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // random request content
  // --------------------------------------------------------------------------
  function automatic logic [31:0] region_span();
    return (m_seg > {16'd0, m_hdr}) ? m_seg - {16'd0, m_hdr} : 32'd4096;
  endfunction

  function automatic logic [31:0] pick_size();
    logic [31:0] unit;
    logic [31:0] top;
    logic [31:0] room;
    int unsigned r;
    unit = region_span() / 40 + 1;
    r    = $urandom_range(99);
    if (r < 40) begin
      // below threshold, scaled to the region
      top = (m_thr == 0) ? 32'd0 : m_thr - 1;
      if (top > unit) top = unit;
      return $urandom_range(top);
    end else if (r < 75) begin
      // at or above threshold
      room = 32'hFFFF_FFFF - m_thr;
      top  = (unit * 2 < room) ? unit * 2 : room;
      return m_thr + $urandom_range(top);
    end else if (r < 90) begin
      return $urandom;
    end else begin
      // around the exact fit of what is left
      room = (m_seg > m_next) ? m_seg - m_next : 32'd0;
      return room + $urandom_range(2) - 32'd1;
    end
  endfunction

  function automatic logic [31:0] pick_free_off();
    int unsigned r;
    int unsigned j;
    logic [31:0] off;
    r = $urandom_range(99);
    if (live_blocks.size() != 0 && r < 60) begin
      j   = $urandom_range(live_blocks.size() - 1);
      off = live_blocks[j];
      // keep some around for double frees
      if ($urandom_range(9) < 7) live_blocks.delete(j);
    end else if (r < 80) begin
      off = {16'd0, m_hdr} + $urandom_range(region_span() - 1);
    end else if (r < 90) begin
      case ($urandom_range(3))
        0:       off = {16'd0, m_hdr} - 32'd1;
        1:       off = {16'd0, m_hdr};
        2:       off = m_seg - 32'd1;
        default: off = m_seg;
      endcase
    end else begin
      off = $urandom;
    end
    return off;
  endfunction

  function automatic void set_idle_mode(input int m);
    case (m % 4)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 88; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 88; end
      default: begin send_idle_pct = 21; stall_pct = 21; end
    endcase
  endfunction

  function automatic reply_t fresh_reply(input stat_t st, input logic bad,
                                         input logic [31:0] blk);
    reply_t r;
    r        = '0;
    r.status = st;
    r.bad    = bad;
    r.blk    = blk;
    r.free   = FREE_RST;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic kind, input logic [31:0] size,
                                       input logic [31:0] off, input bit fixed,
                                       input reply_t want);
    stim_row_t s;
    s.kind  = kind;
    s.size  = size;
    s.off   = off;
    s.fixed = fixed;
    s.want  = want;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // drivers: called at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_word(input logic kind, input logic [31:0] size, input logic [31:0] off,
                           input bit fixed, input reply_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.req_size   <= size;
    req_ch.req_offset <= off;
    pend_fixed = fixed;
    pend_want  = want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // returns at a falling edge with nothing outstanding
  task automatic drain_replies();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SEGMENT:   begin m_seg = data;       restart_region(); end
      REG_HEADER:    begin m_hdr = data[15:0]; restart_region(); end
      REG_THRESHOLD: m_thr = data;
      default:       ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on accept, check on reply
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    reply_t got;
    reply_t want;
    logic   moved;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      moved = cfg_we;
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved          = 1'b1;
        got.status     = stat_t'(rsp_ch.status);
        got.bad        = rsp_ch.bad_offset;
        got.blk        = rsp_ch.block_offset;
        got.used       = rsp_ch.used_total;
        got.free       = rsp_ch.free_total;
        got.trk        = rsp_ch.frags_tracked;
        got.busy       = rsp_ch.frags_busy;
        got.peak       = rsp_ch.frags_busy_peak;
        got.lg_bytes   = rsp_ch.large_total;
        if (pending_replies.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: reply word with nothing outstanding, st=%0d off=%h",
                     $realtime, got.status, got.blk);
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: reply mismatch", $realtime);
              $display("  exp st=%0d bad=%b off=%h used=%h free=%h trk=%0d busy=%0d pk=%0d lg=%h",
                       want.status, want.bad, want.blk, want.used, want.free, want.trk,
                       want.busy, want.peak, want.lg_bytes);
              $display("  got st=%0d bad=%b off=%h used=%h free=%h trk=%0d busy=%0d pk=%0d lg=%h",
                       got.status, got.bad, got.blk, got.used, got.free, got.trk,
                       got.busy, got.peak, got.lg_bytes);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        want  = predict_reply(req_ch.req_type, req_ch.req_size, req_ch.req_offset);
        // block handed out: candidate for a later free
        if (want.status == STAT_NEW || want.status == STAT_REUSE) begin
          live_blocks.push_back(want.blk);
          if (live_blocks.size() > LIVE_MAX) void'(live_blocks.pop_front());
        end
        pending_replies.push_back(pend_fixed ? pend_want : want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog: no handshake for too long
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("bump_allocator_large_frag_recycle_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    int          p;
    int          k;
    int          n_items;
    logic [31:0] b0;
    stim_row_t   row;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ALLOC;
    req_ch.req_size   = '0;
    req_ch.req_offset = '0;
    pend_fixed        = 1'b0;
    pend_want         = '0;
    fail_cnt          = 0;
    quiet_cycles      = 0;
    set_idle_mode(0);
    m_seg = SEG_RST;
    m_hdr = HDR_RST;
    m_thr = THR_RST;
    restart_region();

    // directed table, default geometry; b0 is the first large block
    b0 = {16'd0, HDR_RST} + 32'd100;
    dir_tab.push_back(mk_row(REQ_ALLOC, 32'd0, 32'd0, 1,
                             fresh_reply(STAT_NEW, 1'b0, {16'd0, HDR_RST})));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, 32'd0, 1,
                             fresh_reply(STAT_FREE_UNTRK, 1'b1, 32'd0)));
    dir_tab.push_back(mk_row(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                             fresh_reply(STAT_FREE_UNTRK, 1'b1, 32'd0)));
    dir_tab.push_back(mk_row(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                             fresh_reply(STAT_NOMEM, 1'b0, 32'd0)));
    // exact fit of the whole region is refused
    dir_tab.push_back(mk_row(REQ_ALLOC, FREE_RST, 32'd0, 1,
                             fresh_reply(STAT_NOMEM, 1'b0, 32'd0)));
    dir_tab.push_back(mk_row(REQ_ALLOC, 32'd100, 32'd0, 0, '0));
    dir_tab.push_back(mk_row(REQ_ALLOC, MIB, 32'd0, 0, '0));
    dir_tab.push_back(mk_row(REQ_ALLOC, 2 * MIB, 32'd0, 0, '0));
    // free of an in-use fragment, then a second free of it
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, b0, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, b0, 0, '0));
    dir_tab.push_back(mk_row(REQ_ALLOC, MIB, 32'd0, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, b0 + MIB, 0, '0));
    // released fragment too small, then one that fits
    dir_tab.push_back(mk_row(REQ_ALLOC, 3 * MIB, 32'd0, 0, '0));
    dir_tab.push_back(mk_row(REQ_ALLOC, MIB + MIB / 2, 32'd0, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, 32'd4100, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, SEG_RST - 32'd1, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, SEG_RST, 0, '0));
    dir_tab.push_back(mk_row(REQ_ALLOC, THR_RST - 32'd1, 32'd0, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, {16'd0, HDR_RST}, 0, '0));
    dir_tab.push_back(mk_row(REQ_FREE, 32'd0, {16'd0, HDR_RST} - 32'd1, 0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      @(negedge clk);
      send_word(row.kind, row.size, row.off, row.fixed, row.want);
    end

    // random phases, one geometry each
    for (p = 0; p < N_PHASES; p++) begin
      drain_replies();
      n_items = 230;
      case (p)
        0: ;  // keep default geometry and state
        1: begin
          write_reg(REG_THRESHOLD, 32'd1);
          write_reg(REG_SEGMENT, 32'hFFFF_FFFF);
          write_reg(REG_HEADER, 32'h0000_FFFF);
        end
        2: begin
          write_reg(REG_THRESHOLD, 32'h0000_0800);
          write_reg(REG_SEGMENT, 32'h0001_0000);
          write_reg(REG_HEADER, 32'd0);
        end
        3: begin
          write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
          write_reg(REG_SEGMENT, 32'd0);
          write_reg(REG_HEADER, 32'h0000_0100);
          n_items = 50;
        end
        4: begin
          // header past the segment end
          write_reg(REG_THRESHOLD, 32'h0000_0100);
          write_reg(REG_SEGMENT, 32'h0000_0F00);
          write_reg(REG_HEADER, 32'h0000_1000);
          n_items = 50;
        end
        5: begin
          write_reg(REG_THRESHOLD, $urandom_range(32'h0010_0000, 1));
          write_reg(REG_SEGMENT, $urandom_range(32'h1000_0000, 32'h0010_0000));
          write_reg(REG_HEADER, $urandom);
          write_reg(REG_SPARE, $urandom);
        end
        default: begin
          write_reg(REG_THRESHOLD, MIB);
          write_reg(REG_SEGMENT, 32'h8000_0000 | $urandom_range(32'hFFFF));
          write_reg(REG_HEADER, 32'd0);
        end
      endcase

      for (k = 0; k < n_items; k++) begin
        set_idle_mode(k / 40 + p);
        if (k % 97 == 96) drain_replies();
        // same segment value again restarts the region mid-phase
        if (p == 6 && k == 100) begin
          drain_replies();
          write_reg(REG_SEGMENT, m_seg);
        end
        @(negedge clk);
        if ($urandom_range(99) < 50)
          send_word(REQ_ALLOC, pick_size(), $urandom, 0, '0);
        else
          send_word(REQ_FREE, $urandom, pick_free_off(), 0, '0);
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0)
      $display("bump_allocator_large_frag_recycle_core verification clean");
    else
      $display("bump_allocator_large_frag_recycle_core verification failed");
    $finish;
  end

endmodule
